// ===== rtl/lcdrf_pkg.sv =====
// Shared types and constants of the LCD register file with palette memories.
// Depends on nothing; used by lcdrf_pal_mem and the top level.
package lcdrf_pkg;

  // LCD register window 0xFF40..0xFF4B
  localparam logic [15:0] LCD_BASE = 16'hFF40;
  localparam int          LCD_REGS = 12;
  localparam int          OFF_W    = 4;

  // register offsets inside the LCD window
  localparam logic [OFF_W-1:0] OFF_CTRL = 4'd0;
  localparam logic [OFF_W-1:0] OFF_STAT = 4'd1;
  localparam logic [OFF_W-1:0] OFF_LY   = 4'd4;
  localparam logic [OFF_W-1:0] OFF_LYC  = 4'd5;
  localparam logic [OFF_W-1:0] OFF_DMA  = 4'd6;

  // palette index and data ports
  localparam logic [15:0] ADDR_BG_IDX   = 16'hFF68;
  localparam logic [15:0] ADDR_BG_DATA  = 16'hFF69;
  localparam logic [15:0] ADDR_OBJ_IDX  = 16'hFF6A;
  localparam logic [15:0] ADDR_OBJ_DATA = 16'hFF6B;

  // bit masks
  localparam logic [7:0] BIT7_MASK    = 8'h80;
  localparam logic [7:0] STAT_WR_MASK = 8'h78;
  localparam logic [7:0] STAT_LO_MASK = 8'h07;
  localparam logic [7:0] STAT_HI_MASK = 8'hF8;
  localparam logic [7:0] STAT_MODE2   = 8'h02;
  localparam logic [7:0] STAT_COINC   = 8'h04;
  localparam logic [7:0] UNMAPPED_RD  = 8'hFF;
  localparam logic [5:0] IDX_MASK     = 6'h3F;
  localparam int         IDX_SPAN     = 64;

  // power-on values of the LCD registers
  localparam logic [7:0] LCD_RESET [LCD_REGS] = '{
    8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'hFC, 8'hFF, 8'hFF, 8'h00, 8'h00
  };

  // where the read byte of a result comes from
  typedef enum logic [1:0] {
    RD_REG = 2'd0,
    RD_BG  = 2'd1,
    RD_OBJ = 2'd2
  } rd_src_e;

  // bus word in
  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  // result word out
  typedef struct packed {
    logic [7:0] read_data;
    logic       dma_request;
    logic [7:0] dma_page;
    logic       ppu_restart;
  } out_word_t;

  // request to one palette unit
  typedef struct packed {
    logic       idx_we;
    logic       data_we;
    logic       data_re;
    logic [7:0] wdata;
  } pal_req_t;

  // state seen from one palette unit
  typedef struct packed {
    logic [7:0] index;
    logic [7:0] rd_data;
  } pal_rsp_t;

endpackage

// ===== rtl/lcdrf_stream_if.sv =====
// Valid/ready channel carrying one payload word per handshake.
// Depends on nothing; the payload type is given where it is instantiated.
interface lcdrf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lcdrf_pal_mem.sv =====
// One colour palette: index register with auto-increment and a data memory.
// Depends on lcdrf_pkg.
module lcdrf_pal_mem #(
  parameter int PALETTE_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdrf_pkg::pal_req_t req_i,
  output lcdrf_pkg::pal_rsp_t rsp_o
);
  import lcdrf_pkg::*;

  localparam int SLOT_W    = (PALETTE_BYTES > 1) ? $clog2(PALETTE_BYTES) : 1;
  localparam int SUB_STEPS = (IDX_SPAN + PALETTE_BYTES - 1) / PALETTE_BYTES - 1;

  logic [7:0]              idx_q;
  logic [7:0]              mem [PALETTE_BYTES];
  logic [PALETTE_BYTES-1:0] vld_q;
  logic [7:0]              rdat_q;
  logic                    rvld_q;
  logic [SLOT_W-1:0]       slot;

  // fold the 6-bit index into the memory depth by repeated subtraction
  function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] idx);
    logic [6:0] s;
    s = {1'b0, idx[5:0] & IDX_MASK};
    for (int k = 0; k < SUB_STEPS; k++) begin
      if (s >= 7'(PALETTE_BYTES)) begin
        s = s - 7'(PALETTE_BYTES);
      end
    end
    return s[SLOT_W-1:0];
  endfunction

  assign slot = slot_of(idx_q);

  // index register: load on index write, bump after data write when bit 7 set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (req_i.idx_we) begin
      idx_q <= req_i.wdata;
    end else if (req_i.data_we && idx_q[7]) begin
      idx_q <= {2'b10, idx_q[5:0] + 6'd1};
    end
  end

  // valid bits: an entry never written reads zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.data_we) begin
        vld_q[slot] <= 1'b1;
      end
      if (req_i.data_re) begin
        rvld_q <= vld_q[slot];
      end
    end
  end

  // memory write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.data_we) begin
      mem[slot] <= req_i.wdata;
    end
    if (req_i.data_re) begin
      rdat_q <= mem[slot];
    end
  end

  assign rsp_o.index   = idx_q;
  assign rsp_o.rd_data = rvld_q ? rdat_q : 8'h00;

endmodule

// ===== rtl/lcd_register_file_with_palette_ram.sv =====
// LCD register file with background and object colour palette memories.
// A result is in the output register in the cycle after its word is accepted.
// Throughput: one bus access per cycle while the sink takes results; each access
// touches the LCD registers or one palette memory port, read data comes off a registered port.
// Reset: LCD registers take their power-on values, palette indexes clear, palette
// valid bits clear at once so unwritten entries read zero; no clearing pass.
module lcd_register_file_with_palette_ram #(
  parameter int PALETTE_BYTES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcdrf_stream_if.sink   in_i,
  lcdrf_stream_if.source out_o
);
  import lcdrf_pkg::*;

  in_word_t         inw;
  logic             in_fire;
  logic             is_wr;
  logic             is_lcd;
  logic [OFF_W-1:0] off;

  logic [7:0] lcd_q [LCD_REGS];
  logic [7:0] lcd_d [LCD_REGS];

  pal_req_t bg_req, obj_req;
  pal_rsp_t bg_rsp, obj_rsp;

  logic       out_vld_q;
  logic [7:0] rd_q, rd_d;
  rd_src_e    src_q, src_d;
  logic       dma_q, dma_d;
  logic [7:0] page_q, page_d;
  logic       rst_pulse_q, rst_pulse_d;
  logic [7:0] rd_out;

  assign inw     = in_i.payload;
  assign in_fire = in_i.valid && in_i.ready;
  assign is_wr   = inw.kind;
  assign off     = inw.address[OFF_W-1:0];
  assign is_lcd  = (inw.address[15:OFF_W] == LCD_BASE[15:OFF_W]) &&
                   (off < OFF_W'(LCD_REGS));

  // take a new word whenever the output register is free or being drained
  assign in_i.ready = !out_vld_q || out_o.ready;

  // palette port requests
  always_comb begin
    bg_req.idx_we   = in_fire && is_wr  && (inw.address == ADDR_BG_IDX);
    bg_req.data_we  = in_fire && is_wr  && (inw.address == ADDR_BG_DATA);
    bg_req.data_re  = in_fire && !is_wr && (inw.address == ADDR_BG_DATA);
    bg_req.wdata    = inw.write_data;
    obj_req.idx_we  = in_fire && is_wr  && (inw.address == ADDR_OBJ_IDX);
    obj_req.data_we = in_fire && is_wr  && (inw.address == ADDR_OBJ_DATA);
    obj_req.data_re = in_fire && !is_wr && (inw.address == ADDR_OBJ_DATA);
    obj_req.wdata   = inw.write_data;
  end

  lcdrf_pal_mem #(
    .PALETTE_BYTES(PALETTE_BYTES)
  ) u_bg_pal (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (bg_req),
    .rsp_o (bg_rsp)
  );

  lcdrf_pal_mem #(
    .PALETTE_BYTES(PALETTE_BYTES)
  ) u_obj_pal (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (obj_req),
    .rsp_o (obj_rsp)
  );

  // register writes, display on/off and DMA side effects
  always_comb begin
    lcd_d       = lcd_q;
    dma_d       = 1'b0;
    page_d      = 8'h00;
    rst_pulse_d = 1'b0;
    if (is_wr && is_lcd) begin
      if (off == OFF_STAT) begin
        lcd_d[OFF_STAT] = (inw.write_data & STAT_WR_MASK) | (lcd_q[OFF_STAT] & STAT_LO_MASK);
      end else begin
        if (off == OFF_CTRL) begin
          priority if (inw.write_data[7] && !lcd_q[OFF_CTRL][7]) begin
            lcd_d[OFF_STAT] = (lcd_q[OFF_STAT] & STAT_HI_MASK) | STAT_MODE2 |
                              ((lcd_q[OFF_LY] == lcd_q[OFF_LYC]) ? STAT_COINC : 8'h00);
          end else if (!inw.write_data[7] && lcd_q[OFF_CTRL][7]) begin
            lcd_d[OFF_STAT] = lcd_q[OFF_STAT] & STAT_HI_MASK;
            lcd_d[OFF_LY]   = 8'h00;
            rst_pulse_d     = 1'b1;
          end else begin
            lcd_d[OFF_STAT] = lcd_q[OFF_STAT];
          end
        end
        if (off == OFF_DMA) begin
          dma_d  = 1'b1;
          page_d = inw.write_data;
        end
        lcd_d[off] = inw.write_data;
      end
    end
  end

  // read byte and its source
  always_comb begin
    rd_d  = 8'h00;
    src_d = RD_REG;
    if (!is_wr) begin
      priority if (is_lcd) begin
        rd_d = lcd_q[off];
        if (off == OFF_STAT) begin
          rd_d = lcd_q[off] | BIT7_MASK;
        end
      end else if (inw.address == ADDR_BG_IDX) begin
        rd_d = bg_rsp.index;
      end else if (inw.address == ADDR_BG_DATA) begin
        src_d = RD_BG;
      end else if (inw.address == ADDR_OBJ_IDX) begin
        rd_d = obj_rsp.index;
      end else if (inw.address == ADDR_OBJ_DATA) begin
        src_d = RD_OBJ;
      end else begin
        rd_d = UNMAPPED_RD;
      end
    end
  end

  // update LCD registers on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcd_q <= LCD_RESET;
    end else if (in_fire) begin
      lcd_q <= lcd_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q        <= rd_d;
      src_q       <= src_d;
      dma_q       <= dma_d;
      page_q      <= page_d;
      rst_pulse_q <= rst_pulse_d;
    end
  end

  // pick the palette read port or the latched byte
  always_comb begin
    unique case (src_q)
      RD_BG:   rd_out = bg_rsp.rd_data;
      RD_OBJ:  rd_out = obj_rsp.rd_data;
      RD_REG:  rd_out = rd_q;
      default: rd_out = rd_q;
    endcase
  end

  assign out_o.valid               = out_vld_q;
  assign out_o.payload.read_data   = rd_out;
  assign out_o.payload.dma_request = dma_q;
  assign out_o.payload.dma_page    = page_q;
  assign out_o.payload.ppu_restart = rst_pulse_q;

  // stored status bit 7 is never written
  a_stat_bit7_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lcd_q[OFF_STAT][7])
    else $error("status bit 7 got stored");

  // a shown restart pulse means the display is off and the line counter cleared
  a_restart_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && rst_pulse_q |-> !lcd_q[OFF_CTRL][7] && (lcd_q[OFF_LY] == 8'h00) &&
    (lcd_q[OFF_STAT][2:0] == 3'b000))
    else $error("restart pulse without display off state");

  // no page without a DMA request
  a_page_only_with_dma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !dma_q |-> page_q == 8'h00)
    else $error("DMA page without request");

  // every accepted word leaves a result in the output register
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_vld_q)
    else $error("accepted word produced no result");

  // write results carry a zero read byte
  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_wr |=> rd_out == 8'h00)
    else $error("write returned read data");

endmodule
